### src/rbd_pkg.sv
// Package for the ring buffer deque: field widths, request and status codes,
// register map constants, controller state type and parameter defaults.
// No dependencies.
package rbd_pkg;

    // Fixed field widths.
    localparam int REQ_W   = 3;
    localparam int POS_W   = 6;
    localparam int CNT_W   = 7;
    localparam int STS_W   = 3;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_CAPACITY = '0;
    localparam logic [CNT_W-1:0]   CAP_RESET    = 7'd64;

    // Parameter defaults.
    localparam int DEPTH_DEF      = 64;
    localparam int VALUE_BITS_DEF = 32;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_BACK  = 3'd0,
        REQ_PUSH_FRONT = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_READ       = 3'd4,
        REQ_WRITE      = 3'd5,
        REQ_SEARCH     = 3'd6
    } t_req;

    typedef enum logic [STS_W-1:0] {
        STS_OK        = 3'd0,
        STS_EMPTY     = 3'd1,
        STS_FULL      = 3'd2,
        STS_BAD_POS   = 3'd3,
        STS_NOT_FOUND = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RDATA,
        ST_SEARCH,
        ST_DONE
    } t_state;

endpackage

### src/rbd_ram.sv
// Generic simple dual-port RAM: one write port, one read port with the
// read data registered. No dependencies.
module rbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/rbd_apb.sv
// APB-style configuration register block holding capacity_in_use.
// Depends on rbd_pkg.
module rbd_apb (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rbd_pkg::PADDR_W-1:0] paddr,
    input  logic [rbd_pkg::PDATA_W-1:0] pwdata,
    output logic [rbd_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output logic [rbd_pkg::CNT_W-1:0]   o_capacity
);
    import rbd_pkg::*;

    logic [CNT_W-1:0]     r_capacity;
    logic [CNT_W-1:0]     n_capacity;
    logic [PADDR_W-3:0]   reg_index;

    assign reg_index = paddr[PADDR_W-1:2];

    always_comb begin
        n_capacity = r_capacity;
        if (psel && penable && pwrite && (reg_index == REG_CAPACITY)) begin
            n_capacity = pwdata[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else begin
            r_capacity <= n_capacity;
        end
    end

    assign prdata     = (reg_index == REG_CAPACITY)
                        ? {{(PDATA_W-CNT_W){1'b0}}, r_capacity} : '0;
    assign pready     = 1'b1;
    assign o_capacity = r_capacity;

endmodule

### src/ring_buffer_deque.sv
// Push, write, error and unused requests pass through ST_EXEC and ST_DONE to the
// output register; pop and read add ST_RDATA for the RAM read data; a search walks
// from the head in ST_SEARCH, one slot read per cycle through the single RAM port.
// A new request is taken in ST_IDLE, or in ST_DONE as the result moves out.
// Reset (synchronous, active low) clears head, count, capacity (to 64) and the output
// valid flag; slot contents are not cleared and need no clearing pass.
module ring_buffer_deque #(
    parameter int DEPTH      = rbd_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = rbd_pkg::VALUE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration port.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rbd_pkg::PADDR_W-1:0] paddr,
    input  logic [rbd_pkg::PDATA_W-1:0] pwdata,
    output logic [rbd_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    // Request channel.
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [rbd_pkg::REQ_W-1:0]   i_req_type,
    input  logic [rbd_pkg::POS_W-1:0]   i_position,
    input  logic [VALUE_BITS-1:0]       i_value_in,
    // Result channel.
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [rbd_pkg::STS_W-1:0]   o_status,
    output logic [VALUE_BITS-1:0]       o_value_out,
    output logic [rbd_pkg::POS_W-1:0]   o_found_position,
    output logic [rbd_pkg::CNT_W-1:0]   o_entry_count,
    output logic                        o_is_empty
);
    import rbd_pkg::*;

    // Slot address width and the width of a slot address plus an offset.
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW = ((AW > CNT_W) ? AW : CNT_W) + 1;
    // Highest usable capacity: the register value is clamped to the ring depth.
    localparam int LIM_MAX = (DEPTH < (2**CNT_W - 1)) ? DEPTH : (2**CNT_W - 1);

    // Physical slot of an offset from a base slot. The offset is always below
    // DEPTH wherever this is used, so one compare and subtract wraps it.
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CNT_W-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] slot);
        return (slot == AW'(DEPTH - 1)) ? '0 : slot + AW'(1);
    endfunction

    // Configuration register.
    logic [CNT_W-1:0] capacity;

    rbd_apb u_apb (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_capacity (capacity)
    );

    // Slot store. All accesses are issued by the sequencer below, which works
    // on one request at a time, so a write and a later read of the same slot
    // never overlap and no forwarding is needed.
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [VALUE_BITS-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [VALUE_BITS-1:0] ram_rdata;

    rbd_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Sequencer state, deque pointers and the captured request.
    t_state                r_state, n_state;
    logic [AW-1:0]         r_head, n_head;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [REQ_W-1:0]      r_req, n_req;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic [VALUE_BITS-1:0] r_val, n_val;
    // Search walk: next slot to read and the logical position now being checked.
    logic [AW-1:0]         r_sptr, n_sptr;
    logic [CNT_W-1:0]      r_chk, n_chk;
    // Result staging, loaded into the output register in ST_DONE.
    logic [STS_W-1:0]      r_status, n_status;
    logic [VALUE_BITS-1:0] r_vout, n_vout;
    logic [POS_W-1:0]      r_fpos, n_fpos;
    // Output register.
    logic                  r_out_valid, n_out_valid;
    logic [STS_W-1:0]      r_o_status, n_o_status;
    logic [VALUE_BITS-1:0] r_o_value, n_o_value;
    logic [POS_W-1:0]      r_o_fpos, n_o_fpos;
    logic [CNT_W-1:0]      r_o_count, n_o_count;

    logic [CNT_W-1:0] limit;
    logic             is_full;
    logic             is_empty_now;
    logic             pos_bad;
    logic             out_free;
    logic             in_ready;
    logic             in_xfer;
    logic [AW-1:0]    head_dec;
    logic [AW-1:0]    head_inc;

    // A capacity of zero acts as one, and anything above the depth as the depth.
    always_comb begin
        limit = (capacity == '0) ? CNT_W'(1) : capacity;
        if (limit > CNT_W'(LIM_MAX)) begin
            limit = CNT_W'(LIM_MAX);
        end
    end

    assign is_full      = (r_count >= limit);
    assign is_empty_now = (r_count == '0);
    assign pos_bad      = ({1'b0, r_pos} >= r_count);
    assign head_dec     = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
    assign head_inc     = wrap_inc(r_head);

    // The output register takes a new result when it is empty or its result
    // is being transferred, and a new request is taken in the same cycle as a
    // finished result moves into the output register.
    assign out_free = !r_out_valid || i_out_ready;
    assign in_ready = (r_state == ST_IDLE) || ((r_state == ST_DONE) && out_free);
    assign in_xfer  = i_in_valid && in_ready;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_req       = r_req;
        n_pos       = r_pos;
        n_val       = r_val;
        n_sptr      = r_sptr;
        n_chk       = r_chk;
        n_status    = r_status;
        n_vout      = r_vout;
        n_fpos      = r_fpos;
        n_out_valid = r_out_valid && !i_out_ready;
        n_o_status  = r_o_status;
        n_o_value   = r_o_value;
        n_o_fpos    = r_o_fpos;
        n_o_count   = r_o_count;
        ram_we      = 1'b0;
        ram_waddr   = r_head;
        ram_wdata   = r_val;
        ram_raddr   = r_head;

        if (in_xfer) begin
            n_req = i_req_type;
            n_pos = i_position;
            n_val = i_value_in;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = ST_EXEC;
                end
            end

            ST_EXEC: begin
                n_status = STS_OK;
                n_vout   = '0;
                n_fpos   = '0;
                n_state  = ST_DONE;
                case (r_req)
                    REQ_PUSH_BACK: begin
                        if (is_full) begin
                            n_status = STS_FULL;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = wrap_add(r_head, r_count);
                            n_count   = r_count + CNT_W'(1);
                        end
                    end
                    REQ_PUSH_FRONT: begin
                        if (is_full) begin
                            n_status = STS_FULL;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = head_dec;
                            n_head    = head_dec;
                            n_count   = r_count + CNT_W'(1);
                        end
                    end
                    REQ_POP_FRONT: begin
                        if (is_empty_now) begin
                            n_status = STS_EMPTY;
                        end else begin
                            ram_raddr = r_head;
                            n_head    = head_inc;
                            n_count   = r_count - CNT_W'(1);
                            n_state   = ST_RDATA;
                        end
                    end
                    REQ_POP_BACK: begin
                        if (is_empty_now) begin
                            n_status = STS_EMPTY;
                        end else begin
                            ram_raddr = wrap_add(r_head, r_count - CNT_W'(1));
                            n_count   = r_count - CNT_W'(1);
                            n_state   = ST_RDATA;
                        end
                    end
                    REQ_READ: begin
                        if (pos_bad) begin
                            n_status = STS_BAD_POS;
                        end else begin
                            ram_raddr = wrap_add(r_head, {1'b0, r_pos});
                            n_state   = ST_RDATA;
                        end
                    end
                    REQ_WRITE: begin
                        if (pos_bad) begin
                            n_status = STS_BAD_POS;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = wrap_add(r_head, {1'b0, r_pos});
                        end
                    end
                    REQ_SEARCH: begin
                        if (is_empty_now) begin
                            n_status = STS_NOT_FOUND;
                        end else begin
                            ram_raddr = r_head;
                            n_sptr    = head_inc;
                            n_chk     = '0;
                            n_state   = ST_SEARCH;
                        end
                    end
                    default: begin
                        // The unused request code changes nothing.
                    end
                endcase
            end

            ST_RDATA: begin
                n_vout  = ram_rdata;
                n_state = ST_DONE;
            end

            ST_SEARCH: begin
                // ram_rdata holds the slot of logical position r_chk.
                if (ram_rdata == r_val) begin
                    n_status = STS_OK;
                    n_fpos   = r_chk[POS_W-1:0];
                    n_state  = ST_DONE;
                end else if (r_chk == r_count - CNT_W'(1)) begin
                    n_status = STS_NOT_FOUND;
                    n_state  = ST_DONE;
                end else begin
                    ram_raddr = r_sptr;
                    n_sptr    = wrap_inc(r_sptr);
                    n_chk     = r_chk + CNT_W'(1);
                end
            end

            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    n_o_value   = r_vout;
                    n_o_fpos    = r_fpos;
                    n_o_count   = r_count;
                    n_state     = in_xfer ? ST_EXEC : ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_pos      <= n_pos;
        r_val      <= n_val;
        r_sptr     <= n_sptr;
        r_chk      <= n_chk;
        r_status   <= n_status;
        r_vout     <= n_vout;
        r_fpos     <= n_fpos;
        r_o_status <= n_o_status;
        r_o_value  <= n_o_value;
        r_o_fpos   <= n_o_fpos;
        r_o_count  <= n_o_count;
    end

    assign o_in_ready       = in_ready;
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_o_status;
    assign o_value_out      = r_o_value;
    assign o_found_position = r_o_fpos;
    assign o_entry_count    = r_o_count;
    assign o_is_empty       = (r_o_count == '0);

endmodule

### src/rbd_checker.sv
// Port-level checker for ring_buffer_deque and the bind that attaches it.
// Depends on rbd_pkg and ring_buffer_deque.
module rbd_checker #(
    parameter int VALUE_BITS = rbd_pkg::VALUE_BITS_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [rbd_pkg::STS_W-1:0]   o_status,
    input logic [VALUE_BITS-1:0]       o_value_out,
    input logic [rbd_pkg::POS_W-1:0]   o_found_position,
    input logic [rbd_pkg::CNT_W-1:0]   o_entry_count,
    input logic                        o_is_empty
);
    import rbd_pkg::*;

    // No result is offered in the cycle after a reset.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // The empty flag agrees with the entry count.
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_is_empty == (o_entry_count == '0)))
        else $error("empty flag disagrees with entry count");

    // A failed request carries neither a value nor a found position.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != STS_OK))
            |-> ((o_value_out == '0) && (o_found_position == '0)))
        else $error("failed request carries data");

    // A stalled result holds until it is transferred.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready)
            |=> (o_out_valid && $stable(o_status) && $stable(o_value_out)
                 && $stable(o_found_position) && $stable(o_entry_count)))
        else $error("stalled result changed");

endmodule

bind ring_buffer_deque rbd_checker #(.VALUE_BITS(VALUE_BITS)) u_rbd_checker (.*);
